// ===== src/fcba_pkg.sv =====
// Shared constants, codes and types of the FAT chain block allocator.
// No dependencies; the channel interfaces, the allocator and the testbench import this package.
`default_nettype none

package fcba_pkg;

  // Item field widths
  localparam int OP_W   = 2;
  localparam int HEAD_W = 10;
  localparam int DONE_W = 11;
  localparam int CFG_W  = 11;

  // Managed blocks: one per block address
  localparam int BLK_W      = HEAD_W;
  localparam int MAX_BLOCKS = 1 << BLK_W;
  localparam int CNT_W      = BLK_W + 1;

  localparam logic [CFG_W-1:0] TOTAL_RESET = CFG_W'(MAX_BLOCKS);

  // Operation codes
  localparam logic [OP_W-1:0] OP_ALLOC = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE  = 2'd1;
  localparam logic [OP_W-1:0] OP_LOOK  = 2'd2;

  // One table entry: free flag plus link; link_v low marks end of chain
  typedef struct packed {
    logic             free;
    logic             link_v;
    logic [BLK_W-1:0] link;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // One result item
  typedef struct packed {
    logic [HEAD_W-1:0] head_block;
    logic              head_valid;
    logic [DONE_W-1:0] blocks_done;
    logic              full_res;
  } res_t;

endpackage

`default_nettype wire

// ===== src/fcba_ifs.sv =====
// Handshake channels of the allocator: request, result and configuration write.
// Depends on fcba_pkg for field widths.
`default_nettype none

interface fcba_in_if import fcba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [DONE_W-1:0] block_count;
  logic [HEAD_W-1:0] start_block;

  modport source (output valid, output op, output block_count, output start_block,
                  input ready);
  modport sink   (input valid, input op, input block_count, input start_block,
                  output ready);
endinterface

interface fcba_out_if import fcba_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [HEAD_W-1:0] head_block;
  logic              head_valid;
  logic [DONE_W-1:0] blocks_done;
  logic              full_res;

  modport source (output valid, output head_block, output head_valid,
                  output blocks_done, output full_res, input ready);
  modport sink   (input valid, input head_block, input head_valid,
                  input blocks_done, input full_res, output ready);
endinterface

interface fcba_cfg_if import fcba_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] total_blocks;

  modport source (output valid, output total_blocks, input ready);
  modport sink   (input valid, input total_blocks, output ready);
endinterface

`default_nettype wire

// ===== src/fcba_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module fcba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== src/fat_chain_block_allocator.sv =====
// FAT chain block allocator. After reset the block sweeps its table, one entry
// a cycle, and accepts no request meanwhile; configuration writes are taken at
// any time. An allocate request scans blocks upward from 0, one block per
// cycle, through at most min(total_blocks,1024) blocks, and stops once the
// request is met. A free request walks the chain one block per cycle; a lookup
// reads the entry of its start block and returns its link. The single-ported
// table read sets the one-block-per-cycle pace. One request is in work at a
// time; a finished result sits in an output register, so the next request is
// taken while it waits.
// Depends on fcba_pkg, the channel interfaces and fcba_ram.
`default_nettype none

module fat_chain_block_allocator import fcba_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  fcba_in_if.sink   in_ch,
  fcba_out_if.source out_ch,
  fcba_cfg_if.sink  cfg_ch
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_ALLOC = 3'd2;
  localparam logic [2:0] S_WALK  = 3'd3;
  localparam logic [2:0] S_LOOK  = 3'd4;
  localparam logic [2:0] S_RES   = 3'd5;

  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BLOCKS);

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] addr_r, addr_nxt;
  logic             pend_r, pend_nxt;
  logic [BLK_W-1:0] pend_addr_r, pend_addr_nxt;
  logic [CNT_W-1:0] done_r, done_nxt;
  logic [BLK_W-1:0] prev_r, prev_nxt;
  logic             prev_v_r, prev_v_nxt;
  logic [CNT_W-1:0] want_r, want_nxt;
  logic [CNT_W-1:0] limit_r, limit_nxt;
  logic [CFG_W-1:0] total_r;
  res_t             res_r, res_nxt;
  res_t             out_r;
  logic             out_valid_r, out_valid_nxt;
  logic             load_out;

  logic             we, re;
  logic [BLK_W-1:0] waddr, raddr;
  entry_t           wdata, rd;
  logic [ENTRY_W-1:0] rdata;

  logic             in_take;
  logic             hit, issue;
  logic [CNT_W-1:0] done_after;

  fcba_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(MAX_BLOCKS)
  ) u_table (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign rd = entry_t'(rdata);

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_take     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  assign load_out = (state_r == S_RES) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    done_nxt      = done_r;
    prev_nxt      = prev_r;
    prev_v_nxt    = prev_v_r;
    want_nxt      = want_r;
    limit_nxt     = limit_r;
    res_nxt       = res_r;
    we            = 1'b0;
    waddr         = pend_addr_r;
    wdata         = '0;
    re            = 1'b0;
    raddr         = pend_addr_r;
    hit           = 1'b0;
    issue         = 1'b0;
    done_after    = done_r;

    unique case (state_r)
      S_CLEAR: begin
        we       = 1'b1;
        waddr    = addr_r[BLK_W-1:0];
        wdata    = '{free: 1'b1, link_v: 1'b0, link: '0};
        addr_nxt = addr_r + 1'b1;
        if (addr_r == MAX_CNT - 1'b1) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_take) begin
          done_nxt   = '0;
          prev_v_nxt = 1'b0;
          prev_nxt   = '0;
          pend_nxt   = 1'b0;
          addr_nxt   = '0;
          unique case (in_ch.op)
            OP_ALLOC: begin
              want_nxt  = in_ch.block_count;
              limit_nxt = (total_r > MAX_CNT) ? MAX_CNT : total_r;
              state_nxt = S_ALLOC;
            end
            OP_FREE: begin
              re            = 1'b1;
              raddr         = in_ch.start_block;
              pend_addr_nxt = in_ch.start_block;
              state_nxt     = S_WALK;
            end
            OP_LOOK: begin
              re        = 1'b1;
              raddr     = in_ch.start_block;
              state_nxt = S_LOOK;
            end
            default: begin
              res_nxt   = '0;
              state_nxt = S_RES;
            end
          endcase
        end
      end

      S_ALLOC: begin
        // claim the block read last cycle, then read the next one if still short and below the limit
        hit        = pend_r && rd.free;
        done_after = done_r + CNT_W'(hit);
        if (hit) begin
          we         = 1'b1;
          waddr      = pend_addr_r;
          wdata      = '{free: 1'b0, link_v: prev_v_r, link: prev_r};
          prev_nxt   = pend_addr_r;
          prev_v_nxt = 1'b1;
        end
        done_nxt = done_after;
        issue    = (addr_r < limit_r) && (done_after < want_r);
        pend_nxt = issue;
        if (issue) begin
          re            = 1'b1;
          raddr         = addr_r[BLK_W-1:0];
          pend_addr_nxt = addr_r[BLK_W-1:0];
          addr_nxt      = addr_r + 1'b1;
        end else begin
          res_nxt.head_block  = prev_v_nxt ? prev_nxt : '0;
          res_nxt.head_valid  = prev_v_nxt;
          res_nxt.blocks_done = done_after;
          res_nxt.full_res    = done_after < want_r;
          state_nxt           = S_RES;
        end
      end

      S_WALK: begin
        // free the current block and follow its link in the same cycle
        we         = 1'b1;
        waddr      = pend_addr_r;
        wdata      = '{free: 1'b1, link_v: 1'b0, link: '0};
        done_after = done_r + 1'b1;
        done_nxt   = done_after;
        if (rd.link_v && (done_after < MAX_CNT)) begin
          re            = 1'b1;
          raddr         = rd.link;
          pend_addr_nxt = rd.link;
        end else begin
          res_nxt.head_block  = '0;
          res_nxt.head_valid  = 1'b0;
          res_nxt.blocks_done = done_after;
          res_nxt.full_res    = 1'b0;
          state_nxt           = S_RES;
        end
      end

      S_LOOK: begin
        res_nxt.head_block  = rd.link_v ? rd.link : '0;
        res_nxt.head_valid  = rd.link_v;
        res_nxt.blocks_done = '0;
        res_nxt.full_res    = 1'b0;
        state_nxt           = S_RES;
      end

      S_RES: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      addr_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      total_r     <= TOTAL_RESET;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        total_r <= cfg_ch.total_blocks;
      end
    end
  end

  always_ff @(posedge clk) begin
    pend_addr_r <= pend_addr_nxt;
    done_r      <= done_nxt;
    prev_r      <= prev_nxt;
    prev_v_r    <= prev_v_nxt;
    want_r      <= want_nxt;
    limit_r     <= limit_nxt;
    res_r       <= res_nxt;
    if (load_out) begin
      out_r <= res_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.head_block  = out_r.head_block;
  assign out_ch.head_valid  = out_r.head_valid;
  assign out_ch.blocks_done = out_r.blocks_done;
  assign out_ch.full_res    = out_r.full_res;

  a_pend_in_alloc: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> (state_r == S_ALLOC) && (done_r < want_r))
    else $error("pending scan read outside an unmet allocation");

  a_clear_writes_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> we && wdata.free && !wdata.link_v)
    else $error("clearing sweep did not write a free end-of-chain entry");

  a_take_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> !in_ch.ready)
    else $error("request taken but block stayed ready");

endmodule

`default_nettype wire

// ===== tb/fat_chain_block_allocator_tb.sv =====
// Self-checking testbench for fat_chain_block_allocator: directed and random
// allocate, free and lookup requests, checked against an in-bench table model.
// Depends on fcba_pkg, the channel interfaces in fcba_ifs.sv and the RTL.
`default_nettype none

import fcba_pkg::*;

class fat_table_scoreboard;
  bit               blk_free [MAX_BLOCKS];
  bit               link_ok  [MAX_BLOCKS];
  logic [BLK_W-1:0] link_to  [MAX_BLOCKS];
  logic [CFG_W-1:0] total_blocks;
  res_t             results_due[$];
  int               mismatches;
  int               n_alloc, n_short, n_free, n_look, n_checked;

  function new();
    for (int i = 0; i < MAX_BLOCKS; i++) begin
      blk_free[i] = 1'b1;
      link_ok[i]  = 1'b0;
      link_to[i]  = '0;
    end
    total_blocks = TOTAL_RESET;
  endfunction

  function void set_total(logic [CFG_W-1:0] v);
    total_blocks = v;
  endfunction

  function int pending();
    return results_due.size();
  endfunction

  // Apply one request to the table and return the result it must produce
  function res_t predict_fat_op(logic [OP_W-1:0] op, logic [DONE_W-1:0] want,
                                logic [HEAD_W-1:0] start);
    res_t r;
    int   lim, taken, prev, cur, nxt, steps;
    r     = '0;
    taken = 0;
    case (op)
      OP_ALLOC: begin
        lim  = (int'(total_blocks) > MAX_BLOCKS) ? MAX_BLOCKS : int'(total_blocks);
        prev = -1;
        for (int i = 0; i < lim && taken < int'(want); i++) begin
          if (blk_free[i]) begin
            link_ok[i]  = (prev >= 0);
            link_to[i]  = (prev >= 0) ? BLK_W'(prev) : '0;
            blk_free[i] = 1'b0;
            prev        = i;
            taken++;
          end
        end
        if (prev >= 0) begin
          r.head_block = BLK_W'(prev);
          r.head_valid = 1'b1;
        end
        r.blocks_done = DONE_W'(taken);
        r.full_res    = (taken < int'(want));
        n_alloc++;
        if (r.full_res) n_short++;
      end
      OP_FREE: begin
        cur   = int'(start);
        steps = 0;
        while (cur >= 0 && steps < MAX_BLOCKS) begin
          nxt           = link_ok[cur] ? int'(link_to[cur]) : -1;
          blk_free[cur] = 1'b1;
          link_ok[cur]  = 1'b0;
          link_to[cur]  = '0;
          taken++;
          steps++;
          cur = nxt;
        end
        r.blocks_done = DONE_W'(taken);
        n_free++;
      end
      OP_LOOK: begin
        if (link_ok[start]) begin
          r.head_block = link_to[start];
          r.head_valid = 1'b1;
        end
        n_look++;
      end
      default: ;
    endcase
    return r;
  endfunction

  function res_t note_request(logic [OP_W-1:0] op, logic [DONE_W-1:0] want,
                              logic [HEAD_W-1:0] start);
    res_t r;
    r = predict_fat_op(op, want, start);
    results_due.push_back(r);
    return r;
  endfunction

  function void check_result(res_t got);
    res_t exp_r;
    if (results_due.size() == 0) begin
      $error("unexpected result: head_block %0d head_valid %0d blocks_done %0d full_res %0d",
             got.head_block, got.head_valid, got.blocks_done, got.full_res);
      mismatches++;
      return;
    end
    exp_r = results_due.pop_front();
    n_checked++;
    if (got.head_block !== exp_r.head_block) begin
      $error("head_block: expected %0d, got %0d", exp_r.head_block, got.head_block);
      mismatches++;
    end
    if (got.head_valid !== exp_r.head_valid) begin
      $error("head_valid: expected %0d, got %0d", exp_r.head_valid, got.head_valid);
      mismatches++;
    end
    if (got.blocks_done !== exp_r.blocks_done) begin
      $error("blocks_done: expected %0d, got %0d", exp_r.blocks_done, got.blocks_done);
      mismatches++;
    end
    if (got.full_res !== exp_r.full_res) begin
      $error("full_res: expected %0d, got %0d", exp_r.full_res, got.full_res);
      mismatches++;
    end
  endfunction
endclass

module fat_chain_block_allocator_tb;

  localparam logic [OP_W-1:0] OP_NONE = 2'd3;
  localparam int PHASE_ITEMS = 44;

  logic clk = 1'b0;
  logic rst_n;

  fcba_in_if  in_ch();
  fcba_out_if out_ch();
  fcba_cfg_if cfg_ch();

  fat_chain_block_allocator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  fat_table_scoreboard fat_sb = new();

  logic [HEAD_W-1:0] live_heads[$];
  bit offering;
  bit quiet;
  bit park_results;
  int settings_used;

  logic [CFG_W-1:0] phase_totals[9] = '{11'd37, 11'd1024, 11'd5, 11'd2047, 11'd200,
                                        11'd0, 11'd1, 11'd700, 11'd64};

  task automatic send_request(input logic [OP_W-1:0] op, input logic [DONE_W-1:0] cnt,
                              input logic [HEAD_W-1:0] start);
    res_t r;
    in_ch.valid       <= 1'b1;
    in_ch.op          <= op;
    in_ch.block_count <= cnt;
    in_ch.start_block <= start;
    offering = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    r = fat_sb.note_request(op, cnt, start);
    if (op == OP_ALLOC && r.head_valid) live_heads.push_back(r.head_block);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Stop offering and wait for every outstanding result
  task automatic drain_results();
    if (offering) begin
      in_ch.valid <= 1'b0;
      offering = 1'b0;
    end
    while (fat_sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_total(input logic [CFG_W-1:0] v);
    cfg_ch.valid        <= 1'b1;
    cfg_ch.total_blocks <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    fat_sb.set_total(v);
    cfg_ch.valid <= 1'b0;
    settings_used++;
  endtask

  task automatic random_request(output bit counted);
    int               pick, sel, idx;
    logic [OP_W-1:0]  op;
    logic [DONE_W-1:0] cnt;
    logic [HEAD_W-1:0] start;
    pick    = $urandom_range(0, 99);
    cnt     = DONE_W'($urandom_range(0, 2047));
    start   = HEAD_W'($urandom_range(0, 1023));
    counted = 1'b1;
    if (pick < 45) begin
      op  = OP_ALLOC;
      sel = $urandom_range(0, 19);
      if (sel < 12) cnt = DONE_W'($urandom_range(1, 8));
      else if (sel < 17) cnt = DONE_W'($urandom_range(1, 1024));
      else if (sel < 19) cnt = DONE_W'($urandom_range(0, 2047));
      else cnt = '0;
    end else if (pick < 75) begin
      op = OP_FREE;
      // mostly free a live chain; otherwise hit an arbitrary block
      if (live_heads.size() > 0 && $urandom_range(0, 4) != 0) begin
        idx   = $urandom_range(0, live_heads.size() - 1);
        start = live_heads[idx];
        live_heads.delete(idx);
      end
    end else if (pick < 96) begin
      op = OP_LOOK;
      if (live_heads.size() > 0 && $urandom_range(0, 1) == 1)
        start = live_heads[$urandom_range(0, live_heads.size() - 1)];
    end else begin
      op      = OP_NONE;
      counted = 1'b0;
    end
    send_request(op, cnt, start);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready)
        fat_sb.check_result('{head_block:  out_ch.head_block,
                              head_valid:  out_ch.head_valid,
                              blocks_done: out_ch.blocks_done,
                              full_res:    out_ch.full_res});
      if (park_results) begin
        park_results = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (400) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    int  n_items;
    bit  counted;
    rst_n               <= 1'b0;
    in_ch.valid         <= 1'b0;
    in_ch.op            <= OP_ALLOC;
    in_ch.block_count   <= '0;
    in_ch.start_block   <= '0;
    cfg_ch.valid        <= 1'b0;
    cfg_ch.total_blocks <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero request, short chains, double free, full table, unknown op
    write_total(11'd2047);
    send_request(OP_ALLOC, 11'd0, 10'd0);
    send_request(OP_ALLOC, 11'd1, 10'd0);
    send_request(OP_ALLOC, 11'd3, 10'd0);
    send_request(OP_LOOK, 11'd0, 10'd3);
    send_request(OP_LOOK, 11'd0, 10'd0);
    send_request(OP_LOOK, 11'd0, 10'd1023);
    send_request(OP_FREE, 11'd0, 10'd3);
    send_request(OP_FREE, 11'd0, 10'd3);
    send_request(OP_NONE, 11'd2047, 10'd1023);
    send_request(OP_ALLOC, 11'd2047, 10'd0);
    send_request(OP_LOOK, 11'd0, 10'd1023);
    send_request(OP_ALLOC, 11'd1, 10'd0);
    send_request(OP_FREE, 11'd0, 10'd1023);
    send_request(OP_FREE, 11'd0, 10'd0);
    send_request(OP_ALLOC, 11'd1024, 10'd0);
    send_request(OP_FREE, 11'd2047, 10'd1023);
    drain_results();
    write_total(11'd0);
    send_request(OP_ALLOC, 11'd5, 10'd0);
    send_request(OP_LOOK, 11'd0, 10'd512);
    send_request(OP_FREE, 11'd0, 10'd512);
    drain_results();
    write_total(11'd1);
    send_request(OP_ALLOC, 11'd2, 10'd0);
    send_request(OP_FREE, 11'd0, 10'd0);
    live_heads.delete();

    // Random phases, one total_blocks setting each
    foreach (phase_totals[p]) begin
      drain_results();
      write_total(phase_totals[p]);
      if (p == 1) park_results = 1'b1;
      if (p == $size(phase_totals) - 1) quiet = 1'b1;
      n_items = 0;
      while (n_items < PHASE_ITEMS) begin
        random_request(counted);
        if (counted) n_items++;
      end
    end

    drain_results();
    repeat (20) @(posedge clk);
    $display("run covered %0d allocations (%0d came up short), %0d frees, %0d lookups",
             fat_sb.n_alloc, fat_sb.n_short, fat_sb.n_free, fat_sb.n_look);
    $display("%0d results checked across %0d total_blocks settings",
             fat_sb.n_checked, settings_used);
    if (fat_sb.mismatches == 0 && fat_sb.pending() == 0) begin
      $display("fat_chain_block_allocator_tb passed");
    end else begin
      $display("fat_chain_block_allocator_tb failed");
    end
    $finish;
  end

  // Watchdog: fails the run if it has not finished in time
  initial begin
    #8000000;
    $display("fat_chain_block_allocator_tb failed");
    $finish;
  end

endmodule

`default_nettype wire
